// File: rtl/stereo_sad_disparity_top_macros.svh
// assertion macros for the stereo disparity block
`ifndef STEREO_SAD_DISPARITY_TOP_MACROS_SVH
`define STEREO_SAD_DISPARITY_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stereo disparity check failed");

// next-cycle implication, sampled on clk, off during reset
`define SSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stereo disparity check failed");

`endif

// File: rtl/ssd_pkg.sv
// shared types, constants and functions of the stereo disparity block
`default_nettype none
package ssd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RANGE = 2'd3;

  localparam int WIDTH_CFG_W  = 11;
  localparam int HEIGHT_CFG_W = 11;
  localparam int BLOCK_CFG_W  = 5;
  localparam int RANGE_CFG_W  = 7;

  localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [BLOCK_CFG_W-1:0]  BLOCK_RESET  = 5'd8;
  localparam logic [RANGE_CFG_W-1:0]  RANGE_RESET  = 7'd32;

  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;
  localparam int HT_W       = 12;

  localparam int CHAN_W      = 8;
  localparam int DISP_W      = 7;
  localparam int COORD_W     = 10;
  localparam int PIX_SAD_W   = 10;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t blue;
    chan_t green;
    chan_t red;
  } pixel_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic acc;
    logic drain;
  } cell_ctl_t;

  function automatic chan_t abs_diff(chan_t a, chan_t b);
    return (a > b) ? chan_t'(a - b) : chan_t'(b - a);
  endfunction

  function automatic logic [PIX_SAD_W-1:0] pix_sad(pixel_t a, pixel_t b);
    return PIX_SAD_W'(abs_diff(a.red, b.red)) + PIX_SAD_W'(abs_diff(a.green, b.green))
         + PIX_SAD_W'(abs_diff(a.blue, b.blue));
  endfunction

endpackage
`default_nettype wire

// File: rtl/ssd_if.sv
// stream interfaces for pixel pair items and disparity items
`default_nettype none
interface ssd_in_if;
  logic          valid;
  logic          ready;
  ssd_pkg::chan_t left_red;
  ssd_pkg::chan_t left_green;
  ssd_pkg::chan_t left_blue;
  ssd_pkg::chan_t right_red;
  ssd_pkg::chan_t right_green;
  ssd_pkg::chan_t right_blue;

  modport source(output valid, left_red, left_green, left_blue, right_red, right_green,
                 right_blue, input ready);
  modport sink(input valid, left_red, left_green, left_blue, right_red, right_green,
               right_blue, output ready);
endinterface

interface ssd_out_if;
  logic                         valid;
  logic                         ready;
  logic [ssd_pkg::DISP_W-1:0]   disparity;
  logic [ssd_pkg::COORD_W-1:0]  pixel_column;
  logic [ssd_pkg::COORD_W-1:0]  pixel_row;
  logic                         frame_done;

  modport source(output valid, disparity, pixel_column, pixel_row, frame_done, input ready);
  modport sink(input valid, disparity, pixel_column, pixel_row, frame_done, output ready);
endinterface
`default_nettype wire

// File: rtl/ssd_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module ssd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: rtl/ssd_cell.sv
// one disparity cell: shifts right pixels along, accumulates the block cost
`default_nettype none
module ssd_cell #(
  parameter int COST_W = 18
) (
  input  logic               clk,
  input  ssd_pkg::cell_ctl_t ctl,
  input  ssd_pkg::pixel_t    left_pix,
  input  ssd_pkg::pixel_t    pix_in,
  input  logic [COST_W-1:0]  cost_in,
  output ssd_pkg::pixel_t    pix_out,
  output logic [COST_W-1:0]  cost_out
);

  ssd_pkg::pixel_t   pix_r;
  logic [COST_W-1:0] cost_r;
  logic [COST_W-1:0] cost_nxt;

  always_comb begin
    cost_nxt = cost_r;
    priority if (ctl.clear) begin
      cost_nxt = '0;
    end else if (ctl.drain) begin
      cost_nxt = cost_in;
    end else if (ctl.acc) begin
      cost_nxt = cost_r + COST_W'(ssd_pkg::pix_sad(left_pix, pix_in));
    end
  end

  always_ff @(posedge clk) begin
    cost_r <= cost_nxt;
    if (ctl.shift) begin
      pix_r <= pix_in;
    end
  end

  assign pix_out  = pix_r;
  assign cost_out = cost_r;

endmodule
`default_nettype wire

// File: rtl/stereo_sad_disparity_top.sv
// top level of the stereo block matching disparity unit
`default_nettype none
// Accepts one left/right pixel pair item per idle period in raster order, stores it in a
// line ram of MAX_BLOCK rows and, for each interior pixel, returns the disparity with the
// smallest sum of absolute rgb differences (ties go to the smaller disparity). The search
// runs on a chain of MAX_DISPARITY+1 cells: in the run state each cycle one ram word (left
// and right pixel of one column) is read, right pixels shift one cell per cycle while the
// left pixel is broadcast, so cell d accumulates the cost for disparity d. An item with no
// result returns from setup to idle. With h = block_size/2 and D = min(search_range, x-h),
// an item with a result reads 2*h*(D+2*h) ram words in the run state, then passes through
// drain, cost scan and output load; the single ram read port bounds the search rate. The
// line store has no clearing pass: only entries written in the current frame are read.
module stereo_sad_disparity_top #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_BLOCK     = 16,
  parameter int MAX_DISPARITY = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ssd_in_if.sink                          in_if,
  ssd_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [ssd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ssd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCL_W  = $clog2(MAX_WIDTH + 1);
  localparam int DIM_W  = (WCL_W >= ssd_pkg::HT_W) ? WCL_W + 1 : ssd_pkg::HT_W;
  localparam int SLOT_W = $clog2(MAX_BLOCK);
  localparam int DEPTH  = MAX_BLOCK * MAX_WIDTH;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int H_W    = $clog2(MAX_BLOCK / 2 + 1);
  localparam int B_W    = $clog2(MAX_BLOCK + 1);
  localparam int BS_W   = (B_W > ssd_pkg::BLOCK_CFG_W) ? B_W : ssd_pkg::BLOCK_CFG_W;
  localparam int D_W    = $clog2(MAX_DISPARITY + 1);
  localparam int SR_W   = (D_W > ssd_pkg::RANGE_CFG_W) ? D_W : ssd_pkg::RANGE_CFG_W;
  localparam int T_W    = $clog2(MAX_DISPARITY + MAX_BLOCK);
  localparam int COST_W = $clog2(MAX_BLOCK * MAX_BLOCK * 765 + 1);
  localparam int NCELL  = MAX_DISPARITY + 1;
  localparam int PIX_W  = $bits(ssd_pkg::pixel_t);
  localparam int HTC_W  = ssd_pkg::HT_W;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_RUN   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_SCAN  = 6'b010000,
    S_PUSH  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [ssd_pkg::WIDTH_CFG_W-1:0]  cfg_w_r;
  logic [ssd_pkg::HEIGHT_CFG_W-1:0] cfg_h_r;
  logic [ssd_pkg::BLOCK_CFG_W-1:0]  cfg_bs_r;
  logic [ssd_pkg::RANGE_CFG_W-1:0]  cfg_sr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r  <= ssd_pkg::WIDTH_RESET;
      cfg_h_r  <= ssd_pkg::HEIGHT_RESET;
      cfg_bs_r <= ssd_pkg::BLOCK_RESET;
      cfg_sr_r <= ssd_pkg::RANGE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssd_pkg::REG_IMAGE_WIDTH:  cfg_w_r  <= ssd_pkg::WIDTH_CFG_W'(cfg_data);
        ssd_pkg::REG_IMAGE_HEIGHT: cfg_h_r  <= ssd_pkg::HEIGHT_CFG_W'(cfg_data);
        ssd_pkg::REG_BLOCK_SIZE:   cfg_bs_r <= ssd_pkg::BLOCK_CFG_W'(cfg_data);
        ssd_pkg::REG_SEARCH_RANGE: cfg_sr_r <= ssd_pkg::RANGE_CFG_W'(cfg_data);
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] w_eff;
  logic [HTC_W-1:0] ht_eff;
  logic [BS_W-1:0]  bs_c;
  logic [H_W-1:0]   h_c;
  logic [B_W-1:0]   th1_c;
  logic [D_W-1:0]   win_c;

  always_comb begin
    if (cfg_w_r == '0) begin
      w_eff = DIM_W'(1);
    end else if (DIM_W'(cfg_w_r) > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = DIM_W'(cfg_w_r);
    end
    if (cfg_h_r == '0) begin
      ht_eff = HTC_W'(1);
    end else if (HTC_W'(cfg_h_r) > HTC_W'(ssd_pkg::MAX_HEIGHT)) begin
      ht_eff = HTC_W'(ssd_pkg::MAX_HEIGHT);
    end else begin
      ht_eff = HTC_W'(cfg_h_r);
    end
    if (BS_W'(cfg_bs_r) < BS_W'(2)) begin
      bs_c = BS_W'(2);
    end else if (BS_W'(cfg_bs_r) > BS_W'(MAX_BLOCK)) begin
      bs_c = BS_W'(MAX_BLOCK);
    end else begin
      bs_c = BS_W'(cfg_bs_r);
    end
    h_c   = H_W'(bs_c >> 1);
    th1_c = B_W'((B_W'(h_c) << 1) - B_W'(1));
    if (SR_W'(cfg_sr_r) > SR_W'(MAX_DISPARITY)) begin
      win_c = D_W'(MAX_DISPARITY);
    end else begin
      win_c = D_W'(cfg_sr_r);
    end
  end

  // input handshake and raster position
  logic in_acc;
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;

  logic [COL_W-1:0]          cx_r, cx_nxt;
  logic [ssd_pkg::ROW_W-1:0] cy_r, cy_nxt;
  logic [SLOT_W-1:0]         wslot_r, wslot_nxt;
  logic [ADDR_W-1:0]         wbase_r, wbase_nxt;

  always_comb begin
    logic [DIM_W-1:0] cx1;
    logic [HTC_W-1:0] cy1;
    logic             adv;
    cx1 = DIM_W'(cx_r) + DIM_W'(1);
    cy1 = HTC_W'(cy_r) + HTC_W'(1);
    adv = 1'b0;
    if (cx1 >= w_eff) begin
      cx_nxt = '0;
      if (cy1 >= ht_eff) begin
        cy_nxt = '0;
      end else begin
        cy_nxt = ssd_pkg::ROW_W'(cy1);
        adv    = 1'b1;
      end
    end else begin
      cx_nxt = COL_W'(cx1);
      cy_nxt = (HTC_W'(cy_r) >= ht_eff) ? '0 : cy_r;
    end
    if (cy_nxt == '0) begin
      wslot_nxt = '0;
      wbase_nxt = '0;
    end else if (adv) begin
      if (wslot_r == SLOT_W'(MAX_BLOCK - 1)) begin
        wslot_nxt = '0;
        wbase_nxt = '0;
      end else begin
        wslot_nxt = wslot_r + SLOT_W'(1);
        wbase_nxt = wbase_r + ADDR_W'(MAX_WIDTH);
      end
    end else begin
      wslot_nxt = wslot_r;
      wbase_nxt = wbase_r;
    end
  end

  logic [COL_W-1:0]          cxc_r;
  logic [ssd_pkg::ROW_W-1:0] cyc_r;
  logic [SLOT_W-1:0]         slotc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r    <= '0;
      cy_r    <= '0;
      wslot_r <= '0;
      wbase_r <= '0;
    end else if (in_acc) begin
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      wslot_r <= wslot_nxt;
      wbase_r <= wbase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cxc_r   <= cx_r;
      cyc_r   <= cy_r;
      slotc_r <= wslot_r;
    end
  end

  // setup of one block search
  logic                  emit_c;
  logic [DIM_W-1:0]      xh_c;
  logic [D_W-1:0]        dmax_c;
  logic [COL_W-1:0]      col0_c;
  logic [COL_W-1:0]      x_c;
  logic [ssd_pkg::ROW_W-1:0] y_c;
  logic                  fd_c;
  logic [SLOT_W-1:0]     sslot_c;
  logic [ADDR_W-1:0]     sbase_c;
  logic [T_W-1:0]        tlast_c;

  always_comb begin
    logic [DIM_W-1:0]  cxe;
    logic [HTC_W-1:0]  cye;
    logic [SLOT_W:0]   sle;
    cxe    = DIM_W'(cxc_r);
    cye    = HTC_W'(cyc_r);
    emit_c = (cxe >= DIM_W'(th1_c)) && (cye >= HTC_W'(th1_c))
          && (cxe + DIM_W'(2) <= w_eff) && (cye + HTC_W'(2) <= ht_eff);
    fd_c   = (cxe + DIM_W'(2) == w_eff) && (cye + HTC_W'(2) == ht_eff);
    xh_c   = cxe - DIM_W'(th1_c);
    x_c    = COL_W'(xh_c + DIM_W'(h_c));
    y_c    = ssd_pkg::ROW_W'(cye - HTC_W'(th1_c) + HTC_W'(h_c));
    dmax_c = (xh_c < DIM_W'(win_c)) ? D_W'(xh_c) : win_c;
    col0_c = COL_W'(xh_c - DIM_W'(dmax_c));
    sle    = (SLOT_W + 1)'(slotc_r);
    if (sle >= (SLOT_W + 1)'(th1_c)) begin
      sslot_c = SLOT_W'(sle - (SLOT_W + 1)'(th1_c));
    end else begin
      sslot_c = SLOT_W'(sle + (SLOT_W + 1)'(MAX_BLOCK) - (SLOT_W + 1)'(th1_c));
    end
    sbase_c = ADDR_W'(sslot_c) * ADDR_W'(MAX_WIDTH);
    tlast_c = T_W'(dmax_c) + T_W'(th1_c);
  end

  logic [COL_W-1:0]          x_r;
  logic [ssd_pkg::ROW_W-1:0] y_r;
  logic                      fd_r;
  logic [D_W-1:0]            dmax_r;
  logic [COL_W-1:0]          col0_r;
  logic [T_W-1:0]            tlast_r;
  logic [B_W-1:0]            rlast_r;
  logic [SLOT_W-1:0]         slot_r;
  logic [ADDR_W-1:0]         base_r;
  logic [B_W-1:0]            rcnt_r;
  logic [T_W-1:0]            t_r;
  logic [COL_W-1:0]          col_r;
  logic [D_W-1:0]            sd_r;
  logic                      v1_r, acc1_r;
  logic [COST_W-1:0]         best_r;
  logic [D_W-1:0]            bestd_r;

  logic row_end, blk_end, scan_end;
  assign row_end  = (t_r == tlast_r);
  assign blk_end  = row_end && (rcnt_r == rlast_r);
  assign scan_end = (sd_r == dmax_r);

  logic out_free;
  assign out_free = !out_if.valid || out_if.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SETUP;
      S_SETUP: state_nxt = emit_c ? S_RUN : S_IDLE;
      S_RUN:   if (blk_end) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_SCAN;
      S_SCAN:  if (scan_end) state_nxt = S_PUSH;
      S_PUSH:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      acc1_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == S_RUN);
      acc1_r  <= (state_r == S_RUN) && (t_r >= T_W'(dmax_r));
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SETUP) begin
      x_r     <= x_c;
      y_r     <= y_c;
      fd_r    <= fd_c;
      dmax_r  <= dmax_c;
      col0_r  <= col0_c;
      tlast_r <= tlast_c;
      rlast_r <= th1_c;
      slot_r  <= sslot_c;
      base_r  <= sbase_c;
      rcnt_r  <= '0;
      t_r     <= '0;
      col_r   <= col0_c;
      sd_r    <= '0;
    end else if (state_r == S_RUN) begin
      if (row_end) begin
        t_r    <= '0;
        col_r  <= col0_r;
        rcnt_r <= rcnt_r + B_W'(1);
        if (slot_r == SLOT_W'(MAX_BLOCK - 1)) begin
          slot_r <= '0;
          base_r <= '0;
        end else begin
          slot_r <= slot_r + SLOT_W'(1);
          base_r <= base_r + ADDR_W'(MAX_WIDTH);
        end
      end else begin
        t_r   <= t_r + T_W'(1);
        col_r <= col_r + COL_W'(1);
      end
    end else if (state_r == S_SCAN) begin
      sd_r <= sd_r + D_W'(1);
    end
  end

  // line store: {right, left} per column
  ssd_pkg::pixel_t        in_left, in_right, rd_left, rd_right;
  logic [2*PIX_W-1:0]     rdata;

  assign in_left  = '{blue: in_if.left_blue, green: in_if.left_green, red: in_if.left_red};
  assign in_right = '{blue: in_if.right_blue, green: in_if.right_green, red: in_if.right_red};

  ssd_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(DEPTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (in_acc),
    .waddr(wbase_r + ADDR_W'(cx_r)),
    .wdata({in_right, in_left}),
    .re   (state_r == S_RUN),
    .raddr(base_r + ADDR_W'(col_r)),
    .rdata(rdata)
  );

  assign rd_left  = ssd_pkg::pixel_t'(rdata[PIX_W-1:0]);
  assign rd_right = ssd_pkg::pixel_t'(rdata[2*PIX_W-1:PIX_W]);

  // disparity cell chain
  ssd_pkg::cell_ctl_t ctl;
  assign ctl.clear = (state_r == S_SETUP);
  assign ctl.shift = v1_r;
  assign ctl.acc   = v1_r && acc1_r;
  assign ctl.drain = (state_r == S_SCAN);

  ssd_pkg::pixel_t   pix_w  [NCELL+1];
  logic [COST_W-1:0] cost_w [NCELL+1];

  assign pix_w[0]      = rd_right;
  assign cost_w[NCELL] = '0;

  for (genvar d = 0; d < NCELL; d++) begin : g_cell
    ssd_cell #(
      .COST_W(COST_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_pix(rd_left),
      .pix_in  (pix_w[d]),
      .cost_in (cost_w[d+1]),
      .pix_out (pix_w[d+1]),
      .cost_out(cost_w[d])
    );
  end

  // minimum scan, costs arrive at cell 0 in disparity order
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN) begin
      if (sd_r == '0 || cost_w[0] < best_r) begin
        best_r  <= cost_w[0];
        bestd_r <= sd_r;
      end
    end
  end

  // output register
  logic                         out_valid_r;
  logic [ssd_pkg::DISP_W-1:0]   disp_r;
  logic [ssd_pkg::COORD_W-1:0]  ocol_r, orow_r;
  logic                         ofd_r;
  logic                         load;

  assign load = (state_r == S_PUSH) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      disp_r <= ssd_pkg::DISP_W'(bestd_r);
      ocol_r <= ssd_pkg::COORD_W'(x_r);
      orow_r <= ssd_pkg::COORD_W'(y_r);
      ofd_r  <= fd_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.disparity    = disp_r;
  assign out_if.pixel_column = ocol_r;
  assign out_if.pixel_row    = orow_r;
  assign out_if.frame_done   = ofd_r;

endmodule
`default_nettype wire

// File: rtl/ssd_checker.sv
// port-level checks of the stereo disparity block and their bind
`default_nettype none
`include "stereo_sad_disparity_top_macros.svh"
module ssd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ssd_pkg::DISP_W-1:0]   out_disparity,
  input logic [ssd_pkg::COORD_W-1:0]  out_pixel_column,
  input logic [ssd_pkg::COORD_W-1:0]  out_pixel_row,
  input logic                         out_frame_done
);

  // one item at a time: ready drops after every accepted item
  `SSD_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a fresh result is loaded only while input is held off
  `SSD_ASSERT_NOW(a_result_after_work, $rose(out_valid), $past(!in_ready))

  `SSD_ASSERT_NXT(a_out_valid_holds, out_valid && !out_ready, out_valid)

  `SSD_ASSERT_NXT(a_out_payload_holds, out_valid && !out_ready,
                  $stable(out_disparity) && $stable(out_pixel_column) &&
                  $stable(out_pixel_row) && $stable(out_frame_done))

endmodule

bind stereo_sad_disparity_top ssd_checker u_ssd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_if.valid),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_disparity   (out_if.disparity),
  .out_pixel_column(out_if.pixel_column),
  .out_pixel_row   (out_if.pixel_row),
  .out_frame_done  (out_if.frame_done)
);
`default_nettype wire
